@@ rtl/core/ggpw_pkg.sv @@
// Shared types, constants and helper functions for the greedy grid path walker.
// No dependencies; every module of the block imports this package.
package ggpw_pkg;

    localparam int MASK_W       = 40;
    localparam int LIMIT_W      = 6;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 40;
    localparam int COORD_W      = 3;
    localparam int NBR_IDX_W    = 3;
    localparam int DIST_W       = 8;
    localparam int POS_W        = 5;
    localparam int BIT_IDX_W    = 7;

    localparam int DEF_GRID_ROWS = 8;
    localparam int DEF_GRID_COLS = 5;

    localparam logic [LIMIT_W-1:0]   MOVE_CAP      = 6'd62;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 6'd62;
    localparam logic [NBR_IDX_W-1:0] NBR_LAST      = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_MASK  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_LIMIT = 2'd1;

    localparam logic [2:0] OUT_ON_PATH    = 3'd0;
    localparam logic [2:0] OUT_REACHED    = 3'd1;
    localparam logic [2:0] OUT_STUCK      = 3'd2;
    localparam logic [2:0] OUT_STEP_LIMIT = 3'd3;
    localparam logic [2:0] OUT_BAD_SOURCE = 3'd4;
    localparam logic [2:0] OUT_BAD_GOAL   = 3'd5;
    localparam logic [2:0] OUT_SAME_CELLS = 3'd6;

    typedef struct packed {
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] goal_row;
        logic [COORD_W-1:0] goal_col;
    } query_t;

    typedef struct packed {
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic [2:0]         outcome;
        logic               final_item;
    } step_t;

    // Result of evaluating one neighbour of the current cell
    typedef struct packed {
        logic               open;
        logic [DIST_W-1:0]  sq_dist;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } nbr_eval_t;

    // Row delta in scan order: (+1,+1) (+1,0) (+1,-1) (0,+1) (0,-1) (-1,+1) (-1,-1) (-1,0)
    function automatic logic signed [1:0] nbr_dr(input logic [NBR_IDX_W-1:0] idx);
        logic signed [1:0] d;
        case (idx)
            3'd0, 3'd1, 3'd2: d = 2'sd1;
            3'd3, 3'd4:       d = 2'sd0;
            default:          d = -2'sd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] nbr_dc(input logic [NBR_IDX_W-1:0] idx);
        logic signed [1:0] d;
        case (idx)
            3'd0, 3'd3, 3'd5: d = 2'sd1;
            3'd1, 3'd7:       d = 2'sd0;
            default:          d = -2'sd1;
        endcase
        return d;
    endfunction

    // A cell is open when inside the grid and its mask bit (below MASK_W) is set
    function automatic logic cell_open(
        input logic signed [POS_W-1:0] r,
        input logic signed [POS_W-1:0] c,
        input logic [MASK_W-1:0]       mask,
        input int                      rows,
        input int                      cols
    );
        logic [BIT_IDX_W-1:0] idx;
        logic                 ok;
        idx = BIT_IDX_W'(int'(r[COORD_W-1:0]) * cols + int'(c[COORD_W-1:0]));
        ok  = (r >= 0) && (c >= 0) && (int'(r) < rows) && (int'(c) < cols)
              && (idx < BIT_IDX_W'(MASK_W));
        if (ok)
            ok = mask[idx[5:0]];
        return ok;
    endfunction

endpackage

@@ rtl/core/ggpw_nbr_eval.sv @@
// Shared neighbour evaluator: one neighbour of the current cell per cycle.
// Depends on ggpw_pkg for types, scan-order deltas and the cell_open check.
module ggpw_nbr_eval
    import ggpw_pkg::*;
#(
    parameter int GRID_ROWS = DEF_GRID_ROWS,
    parameter int GRID_COLS = DEF_GRID_COLS
)
(
    input  logic [COORD_W-1:0]   here_row,
    input  logic [COORD_W-1:0]   here_col,
    input  logic [NBR_IDX_W-1:0] nbr_idx,
    input  logic [COORD_W-1:0]   goal_row,
    input  logic [COORD_W-1:0]   goal_col,
    input  logic [MASK_W-1:0]    mask,
    output nbr_eval_t            result
);

    logic signed [POS_W-1:0] cand_r;
    logic signed [POS_W-1:0] cand_c;
    logic signed [POS_W-1:0] diff_r;
    logic signed [POS_W-1:0] diff_c;
    logic [DIST_W-1:0]       sq_r;
    logic [DIST_W-1:0]       sq_c;

    always_comb
    begin
        cand_r = $signed({2'b00, here_row}) + POS_W'(nbr_dr(nbr_idx));
        cand_c = $signed({2'b00, here_col}) + POS_W'(nbr_dc(nbr_idx));
        diff_r = cand_r - $signed({2'b00, goal_row});
        diff_c = cand_c - $signed({2'b00, goal_col});
        // squared distance to the goal, exact in integers
        sq_r   = DIST_W'(DIST_W'(diff_r) * DIST_W'(diff_r));
        sq_c   = DIST_W'(DIST_W'(diff_c) * DIST_W'(diff_c));
        result.open    = cell_open(cand_r, cand_c, mask, GRID_ROWS, GRID_COLS);
        result.sq_dist = sq_r + sq_c;
        result.row     = cand_r[COORD_W-1:0];
        result.col     = cand_c[COORD_W-1:0];
    end

endmodule

@@ rtl/core/greedy_grid_path_walker.sv @@
// Top level of the greedy grid path walker: sequencer, configuration and result register.
// Depends on ggpw_pkg and instantiates ggpw_nbr_eval.
//
// Usage
//  - query channel (query_valid / query_stall / query): one transfer gives a source and a
//    goal cell. query_stall stays high from acceptance until the last result of that
//    query has been loaded into the result register; a new query may then transfer even
//    while that last result still waits to be taken.
//  - step channel (step_valid / step_stall / step): results, one per transfer, in walk
//    order; final_item marks the last result of a query. While step_stall is high and a
//    result is held, that register holds and the sequencer waits to load the next one.
//  - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is always high;
//    index 0 writes the open-cell mask, index 1 the move limit, other indexes are dropped.
// Sequence
//  - a status result (bad source, bad goal, same cells) is loaded from the check state.
//  - each move takes one limit check, a scan in which the shared neighbour evaluator
//    scores the 8 neighbours one after another, and one move state. A walk makes at most
//    62 moves, the move cap; its last result is loaded in the move state, or in the limit
//    check for the step-limit result.
// Reset
//  - rst_n low clears the sequencer and the result valid, opens every grid cell and sets
//    the move limit to 62. No clearing pass is needed.
module greedy_grid_path_walker
    import ggpw_pkg::*;
#(
    parameter int GRID_ROWS = DEF_GRID_ROWS,
    parameter int GRID_COLS = DEF_GRID_COLS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   query_valid,
    output logic                   query_stall,
    input  query_t                 query,
    output logic                   step_valid,
    input  logic                   step_stall,
    output step_t                  step,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LIMIT,
        ST_SCAN,
        ST_MOVE
    } state_t;

    // Control registers
    state_t               state_reg,      state_next;
    logic                 step_valid_reg, step_valid_next;
    logic [NBR_IDX_W-1:0] nbr_idx_reg,    nbr_idx_next;
    logic                 found_reg,      found_next;
    logic [LIMIT_W-1:0]   moves_reg,      moves_next;

    // Configuration registers
    logic [MASK_W-1:0]    mask_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    // Payload registers
    query_t               query_reg,      query_next;
    step_t                step_reg,       step_next;
    logic [COORD_W-1:0]   here_row_reg,   here_row_next;
    logic [COORD_W-1:0]   here_col_reg,   here_col_next;
    logic [DIST_W-1:0]    best_d_reg,     best_d_next;
    logic [COORD_W-1:0]   best_row_reg,   best_row_next;
    logic [COORD_W-1:0]   best_col_reg,   best_col_next;

    nbr_eval_t            nbr;
    logic                 out_free;
    logic                 emit;
    step_t                emit_data;
    logic [LIMIT_W-1:0]   limit_eff;
    logic                 src_ok;
    logic                 goal_ok;

    ggpw_nbr_eval #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_nbr_eval (
        .here_row (here_row_reg),
        .here_col (here_col_reg),
        .nbr_idx  (nbr_idx_reg),
        .goal_row (query_reg.goal_row),
        .goal_col (query_reg.goal_col),
        .mask     (mask_reg),
        .result   (nbr)
    );

    assign query_stall = (state_reg != ST_IDLE);
    assign step_valid  = step_valid_reg;
    assign step        = step_reg;
    assign cfg_ready   = 1'b1;

    // The result register can take a new result when empty or being drained this cycle
    assign out_free  = !step_valid_reg || !step_stall;
    assign limit_eff = (limit_reg > MOVE_CAP) ? MOVE_CAP : limit_reg;

    always_comb
    begin
        src_ok  = cell_open($signed({2'b00, query_reg.start_row}),
                            $signed({2'b00, query_reg.start_col}),
                            mask_reg, GRID_ROWS, GRID_COLS);
        goal_ok = cell_open($signed({2'b00, query_reg.goal_row}),
                            $signed({2'b00, query_reg.goal_col}),
                            mask_reg, GRID_ROWS, GRID_COLS);
    end

    always_comb
    begin
        state_next     = state_reg;
        nbr_idx_next   = nbr_idx_reg;
        found_next     = found_reg;
        moves_next     = moves_reg;
        query_next     = query_reg;
        here_row_next  = here_row_reg;
        here_col_next  = here_col_reg;
        best_d_next    = best_d_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        emit           = 1'b0;
        emit_data      = step_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (query_valid)
                begin
                    query_next = query;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_data.cell_row   = query_reg.start_row;
                    emit_data.cell_col   = query_reg.start_col;
                    emit_data.final_item = 1'b1;
                    state_next           = ST_IDLE;
                    if (!src_ok)
                    begin
                        emit_data.outcome = OUT_BAD_SOURCE;
                    end
                    else if (!goal_ok)
                    begin
                        emit_data.cell_row = query_reg.goal_row;
                        emit_data.cell_col = query_reg.goal_col;
                        emit_data.outcome  = OUT_BAD_GOAL;
                    end
                    else if (query_reg.start_row == query_reg.goal_row
                             && query_reg.start_col == query_reg.goal_col)
                    begin
                        emit_data.outcome = OUT_SAME_CELLS;
                    end
                    else
                    begin
                        // emit the source and start walking from it
                        emit_data.outcome    = OUT_ON_PATH;
                        emit_data.final_item = 1'b0;
                        here_row_next        = query_reg.start_row;
                        here_col_next        = query_reg.start_col;
                        moves_next           = '0;
                        state_next           = ST_LIMIT;
                    end
                end
            end

            ST_LIMIT:
            begin
                if (moves_reg >= limit_eff)
                begin
                    if (out_free)
                    begin
                        emit                 = 1'b1;
                        emit_data.cell_row   = here_row_reg;
                        emit_data.cell_col   = here_col_reg;
                        emit_data.outcome    = OUT_STEP_LIMIT;
                        emit_data.final_item = 1'b1;
                        state_next           = ST_IDLE;
                    end
                end
                else
                begin
                    nbr_idx_next = '0;
                    found_next   = 1'b0;
                    state_next   = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // keep the first neighbour on ties: replace only on strictly smaller distance
                if (nbr.open && (!found_reg || nbr.sq_dist < best_d_reg))
                begin
                    found_next    = 1'b1;
                    best_d_next   = nbr.sq_dist;
                    best_row_next = nbr.row;
                    best_col_next = nbr.col;
                end
                nbr_idx_next = nbr_idx_reg + NBR_IDX_W'(1);
                if (nbr_idx_reg == NBR_LAST)
                begin
                    state_next = ST_MOVE;
                end
            end

            ST_MOVE:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (!found_reg)
                    begin
                        emit_data.cell_row   = here_row_reg;
                        emit_data.cell_col   = here_col_reg;
                        emit_data.outcome    = OUT_STUCK;
                        emit_data.final_item = 1'b1;
                        state_next           = ST_IDLE;
                    end
                    else
                    begin
                        here_row_next      = best_row_reg;
                        here_col_next      = best_col_reg;
                        moves_next         = moves_reg + LIMIT_W'(1);
                        emit_data.cell_row = best_row_reg;
                        emit_data.cell_col = best_col_reg;
                        if (best_row_reg == query_reg.goal_row
                            && best_col_reg == query_reg.goal_col)
                        begin
                            emit_data.outcome    = OUT_REACHED;
                            emit_data.final_item = 1'b1;
                            state_next           = ST_IDLE;
                        end
                        else
                        begin
                            emit_data.outcome    = OUT_ON_PATH;
                            emit_data.final_item = 1'b0;
                            state_next           = ST_LIMIT;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Result register: load on emit, otherwise drop valid once the transfer completes
        step_next = step_reg;
        if (emit)
        begin
            step_valid_next = 1'b1;
            step_next       = emit_data;
        end
        else if (!step_stall)
        begin
            step_valid_next = 1'b0;
        end
        else
        begin
            step_valid_next = step_valid_reg;
        end
    end

    // Sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_valid_reg <= 1'b0;
            nbr_idx_reg    <= '0;
            found_reg      <= 1'b0;
            moves_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_valid_reg <= step_valid_next;
            nbr_idx_reg    <= nbr_idx_next;
            found_reg      <= found_next;
            moves_reg      <= moves_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        query_reg    <= query_next;
        step_reg     <= step_next;
        here_row_reg <= here_row_next;
        here_col_reg <= here_col_next;
        best_d_reg   <= best_d_next;
        best_row_reg <= best_row_next;
        best_col_reg <= best_col_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '1;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OPEN_MASK:  mask_reg  <= cfg_data[MASK_W-1:0];
                CFG_MOVE_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

endmodule
